/* rtl/quad_attitude_mixer_core_defines.svh */
// assertion macros for the attitude mixer core
`ifndef QUAD_ATTITUDE_MIXER_CORE_DEFINES_SVH
`define QUAD_ATTITUDE_MIXER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, muted in reset
`define QAMC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, muted in reset
`define QAMC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/qam_pkg.sv */
package qam_pkg;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQ_C,
        ST_ROOT,
        ST_CORD_INIT,
        ST_CORD,
        ST_CORD_END,
        ST_RATE,
        ST_DIV_INIT,
        ST_DIV_LO,
        ST_DIV_HI,
        ST_DIV_EST,
        ST_DIV_BACK,
        ST_DIV_FIX,
        ST_BL_A,
        ST_BL_B,
        ST_BL_C,
        ST_MIX_P,
        ST_MIX_R,
        ST_MIX,
        ST_OUT
    } state_t;

    // register indexes
    localparam logic [3:0] REG_SENSOR  = 4'd0;
    localparam logic [3:0] REG_BASE    = 4'd1;
    localparam logic [3:0] REG_MIN     = 4'd2;
    localparam logic [3:0] REG_MAX     = 4'd3;
    localparam logic [3:0] REG_PGAIN   = 4'd4;
    localparam logic [3:0] REG_RGAIN   = 4'd5;
    localparam logic [3:0] REG_TILT    = 4'd6;
    localparam logic [3:0] REG_WEIGHT  = 4'd7;

    // status codes
    localparam logic [1:0] STAT_FLY       = 2'd0;
    localparam logic [1:0] STAT_NO_SENSOR = 2'd1;
    localparam logic [1:0] STAT_TILT      = 2'd2;

    // iteration counts
    localparam logic [4:0] ROOT_LAST = 5'd15;
    localparam logic [4:0] CORD_LAST = 5'd15;

    // time handling
    localparam logic [19:0] DT_MAX = 20'd100000;
    localparam logic [16:0] DT_DEF = 17'd4000;

    // gyro scaling: inc = (|rate*dt|*8 + 7812) / 15625
    localparam logic [35:0] DIV_BIAS = 36'd7812;
    localparam logic [35:0] DIV_D    = 36'd15625;

    // floor(2^41 / 15625) split at bit 14 to fit the narrow multiplier port
    localparam logic [16:0] RCP_HI = 17'd8589;
    localparam logic [16:0] RCP_LO = 17'd15312;

    // +-180 degrees with 16 fraction bits
    localparam logic signed [24:0] ANGLE_LIM = 25'sd11796480;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic [29:0] atan_tbl(input logic [3:0] i);
        logic [29:0] v;
        unique case (i)
            4'd0:  v = 30'd754974720;
            4'd1:  v = 30'd445687602;
            4'd2:  v = 30'd235489088;
            4'd3:  v = 30'd119537938;
            4'd4:  v = 30'd60000934;
            4'd5:  v = 30'd30029717;
            4'd6:  v = 30'd15018523;
            4'd7:  v = 30'd7509720;
            4'd8:  v = 30'd3754917;
            4'd9:  v = 30'd1877466;
            4'd10: v = 30'd938734;
            4'd11: v = 30'd469367;
            4'd12: v = 30'd234684;
            4'd13: v = 30'd117342;
            4'd14: v = 30'd58671;
            4'd15: v = 30'd29335;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // divide by 2^24 truncating toward zero
    function automatic logic signed [23:0] trunc24(input logic signed [47:0] v);
        logic signed [47:0] t;
        t = v[47] ? ((v + 48'sd16777215) >>> 24) : (v >>> 24);
        return t[23:0];
    endfunction

    // clamp to the throttle limits, low limit checked first
    function automatic logic [11:0] limit(input logic signed [23:0] t,
                                          input logic [11:0] mn,
                                          input logic [11:0] mx);
        logic [11:0] r;
        if (t < $signed({12'd0, mn}))
            r = mn;
        else if (t > $signed({12'd0, mx}))
            r = mx;
        else
            r = t[11:0];
        return r;
    endfunction

endpackage

/* rtl/quad_attitude_mixer_core.sv */
// channel | handshake            | payload
// in      | in_valid / in_ready   | accel_x/y/z, gyro_pitch/roll, elapsed_us
// out     | out_valid / out_ready | four motors, pitch/roll angle, status
// cfg     | cfg_we                | cfg_index, cfg_data
// with the sensor present each input beat runs, per axis, a pass (squares, 16-step root, 16-step cordic,
// rate, reciprocal divide in init, low, high, estimate, back and fix steps, blend), skipping the cordic
// iterations and its end step on a zero cordic numerator, then a mix on one 26x18 multiplier
// with no sensor the result is ready the cycle after the input beat
// reset clears configuration to defaults and both estimates to zero
// the input stalls until the previous result beat has been taken
module quad_attitude_mixer_core
    import qam_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [16:0] gyro_pitch,
    input  logic signed [16:0] gyro_roll,
    input  logic [19:0]        elapsed_us,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [11:0]        motor_front_left,
    output logic [11:0]        motor_front_right,
    output logic [11:0]        motor_back_right,
    output logic [11:0]        motor_back_left,
    output logic signed [16:0] pitch_angle,
    output logic signed [16:0] roll_angle,
    output logic [1:0]         status,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    state_t state_reg, state_next;

    // configuration
    logic        sensor_reg;
    logic [11:0] base_reg, min_reg, max_reg, pgain_reg, rgain_reg;
    logic [7:0]  tilt_reg;
    logic [15:0] weight_reg;

    // captured sample
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic signed [16:0] gp_reg, gr_reg;
    logic [16:0]        dt_reg;

    // estimates and sequencing
    logic signed [24:0] pest_reg, rest_reg;
    logic               axis_reg;
    logic [4:0]         cnt_reg;

    // shared multiplier and accumulator
    logic signed [25:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [43:0] mul_p;
    logic signed [43:0] prod_reg, sum_reg;

    // root, cordic and divider registers
    logic [31:0]        rad_reg;
    logic [18:0]        rem_reg;
    logic [15:0]        root_reg;
    logic signed [35:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic signed [23:0] acc_reg;
    logic [35:0]        n_reg;
    logic [21:0]        quo_reg;
    logic               neg_reg;

    // result registers
    logic [11:0]        fl_reg, fr_reg, br_reg, bl_reg;
    logic signed [16:0] pang_reg, rang_reg;
    logic [1:0]         stat_reg;

    // helper terms
    logic signed [24:0] cur_est;
    logic signed [22:0] inc_s;
    logic signed [25:0] est_plus;
    logic [16:0]        one_m_w;
    logic [18:0]        rem_sh, trial;
    logic               root_ge;
    logic signed [35:0] cdx, cdy;
    logic               cpos;
    logic signed [16:0] cord_y;
    logic signed [32:0] cz_rnd;
    logic [32:0]        rd_mag;
    logic [39:0]        q_sum;
    logic [35:0]        n_rem;
    logic signed [43:0] bl_tot;
    logic signed [27:0] bl_new;
    logic signed [24:0] bl_sat;
    logic signed [47:0] mx_b, mx_pa, mx_ra;
    logic signed [24:0] tl_pos;
    logic               tilt_hit;
    logic signed [25:0] pest_rnd, rest_rnd;

    assign mul_p = mul_a * mul_b;

    // per-axis operand picks and arithmetic steps
    always_comb
    begin
        cur_est  = axis_reg ? rest_reg : pest_reg;
        inc_s    = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        est_plus = $signed({cur_est[24], cur_est}) + 26'(inc_s);
        one_m_w  = 17'd65536 - {1'b0, weight_reg};
        rem_sh   = {rem_reg[16:0], rad_reg[31:30]};
        trial    = {1'b0, root_reg, 2'b01};
        root_ge  = rem_sh >= trial;
        cdx      = cy_reg >>> cnt_reg[3:0];
        cdy      = cx_reg >>> cnt_reg[3:0];
        cpos     = !cy_reg[35] && (cy_reg != 36'sd0);
        cord_y   = axis_reg ? -17'(ax_reg) : 17'(ay_reg);
        cz_rnd   = (cz_reg + 33'sd128) >>> 8;
        rd_mag   = prod_reg[43] ? 33'(-prod_reg) : prod_reg[32:0];
        // quotient estimate from the two reciprocal partial products, low by at most one
        q_sum    = prod_reg[39:0] + {14'd0, sum_reg[39:14]};
        n_rem    = n_reg - prod_reg[35:0];
        bl_tot   = sum_reg + prod_reg + 44'sd32768;
        bl_new   = 28'(bl_tot >>> 16);
        if (bl_new > 28'(ANGLE_LIM))
            bl_sat = ANGLE_LIM;
        else if (bl_new < -28'(ANGLE_LIM))
            bl_sat = -ANGLE_LIM;
        else
            bl_sat = bl_new[24:0];
        mx_b     = $signed({12'd0, base_reg, 24'd0});
        mx_pa    = 48'(sum_reg);
        mx_ra    = 48'(prod_reg);
        tl_pos   = $signed({1'b0, tilt_reg, 16'd0});
        tilt_hit = (pest_reg > tl_pos) || (pest_reg < -tl_pos)
                || (rest_reg > tl_pos) || (rest_reg < -tl_pos);
        pest_rnd = (26'(pest_reg) + 26'sd128) >>> 8;
        rest_rnd = (26'(rest_reg) + 26'sd128) >>> 8;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = sensor_reg ? ST_SQ_A : ST_OUT;
            ST_SQ_A:      state_next = ST_SQ_B;
            ST_SQ_B:      state_next = ST_SQ_C;
            ST_SQ_C:      state_next = ST_ROOT;
            ST_ROOT:
                if (cnt_reg == ROOT_LAST)
                    state_next = ST_CORD_INIT;
            ST_CORD_INIT: state_next = (cord_y == 17'sd0) ? ST_RATE : ST_CORD;
            ST_CORD:
                if (cnt_reg == CORD_LAST)
                    state_next = ST_CORD_END;
            ST_CORD_END:  state_next = ST_RATE;
            ST_RATE:      state_next = ST_DIV_INIT;
            ST_DIV_INIT:  state_next = ST_DIV_LO;
            ST_DIV_LO:    state_next = ST_DIV_HI;
            ST_DIV_HI:    state_next = ST_DIV_EST;
            ST_DIV_EST:   state_next = ST_DIV_BACK;
            ST_DIV_BACK:  state_next = ST_DIV_FIX;
            ST_DIV_FIX:   state_next = ST_BL_A;
            ST_BL_A:      state_next = ST_BL_B;
            ST_BL_B:      state_next = ST_BL_C;
            ST_BL_C:      state_next = axis_reg ? ST_MIX_P : ST_SQ_A;
            ST_MIX_P:     state_next = ST_MIX_R;
            ST_MIX_R:     state_next = ST_MIX;
            ST_MIX:       state_next = ST_OUT;
            ST_OUT:
                if (out_ready)
                    state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // handshake and multiplier operand selection
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_OUT);
        mul_a     = 26'sd0;
        mul_b     = 18'sd0;
        unique case (state_reg)
            ST_SQ_A:
            begin
                mul_a = axis_reg ? 26'(ay_reg) : 26'(ax_reg);
                mul_b = axis_reg ? 18'(ay_reg) : 18'(ax_reg);
            end
            ST_SQ_B:
            begin
                mul_a = 26'(az_reg);
                mul_b = 18'(az_reg);
            end
            ST_RATE:
            begin
                mul_a = axis_reg ? 26'(gr_reg) : 26'(gp_reg);
                mul_b = $signed({1'b0, dt_reg});
            end
            ST_DIV_LO:
            begin
                mul_a = $signed({1'b0, n_reg[35:11]});
                mul_b = $signed({1'b0, RCP_LO});
            end
            ST_DIV_HI:
            begin
                mul_a = $signed({1'b0, n_reg[35:11]});
                mul_b = $signed({1'b0, RCP_HI});
            end
            ST_DIV_BACK:
            begin
                mul_a = $signed({4'd0, quo_reg});
                mul_b = $signed({1'b0, DIV_D[16:0]});
            end
            ST_BL_A:
            begin
                mul_a = est_plus;
                mul_b = $signed({2'b00, weight_reg});
            end
            ST_BL_B:
            begin
                mul_a = 26'(acc_reg);
                mul_b = $signed({1'b0, one_m_w});
            end
            ST_MIX_P:
            begin
                mul_a = 26'(pest_reg);
                mul_b = $signed({6'd0, pgain_reg});
            end
            ST_MIX_R:
            begin
                mul_a = 26'(rest_reg);
                mul_b = $signed({6'd0, rgain_reg});
            end
            default:
            begin
                mul_a = 26'sd0;
                mul_b = 18'sd0;
            end
        endcase
    end

    // control state, configuration and estimates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sensor_reg <= 1'b0;
            base_reg   <= 12'd1300;
            min_reg    <= 12'd1000;
            max_reg    <= 12'd2000;
            pgain_reg  <= 12'd512;
            rgain_reg  <= 12'd512;
            tilt_reg   <= 8'd30;
            weight_reg <= 16'd64225;
            pest_reg   <= 25'sd0;
            rest_reg   <= 25'sd0;
            axis_reg   <= 1'b0;
            cnt_reg    <= 5'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SENSOR: sensor_reg <= cfg_data[0];
                    REG_BASE:   base_reg   <= cfg_data[11:0];
                    REG_MIN:    min_reg    <= cfg_data[11:0];
                    REG_MAX:    max_reg    <= cfg_data[11:0];
                    REG_PGAIN:  pgain_reg  <= cfg_data[11:0];
                    REG_RGAIN:  rgain_reg  <= cfg_data[11:0];
                    REG_TILT:   tilt_reg   <= cfg_data[7:0];
                    REG_WEIGHT: weight_reg <= cfg_data;
                    default:    ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE:      axis_reg <= 1'b0;
                ST_SQ_C:      cnt_reg  <= 5'd0;
                ST_ROOT:      cnt_reg  <= cnt_reg + 5'd1;
                ST_CORD_INIT: cnt_reg  <= 5'd0;
                ST_CORD:      cnt_reg  <= cnt_reg + 5'd1;
                ST_BL_C:
                begin
                    if (axis_reg)
                        rest_reg <= bl_sat;
                    else
                        pest_reg <= bl_sat;
                    axis_reg <= 1'b1;
                end
                default:      ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_p;
        unique case (state_reg)
            ST_IDLE:
            begin
                ax_reg <= accel_x;
                ay_reg <= accel_y;
                az_reg <= accel_z;
                gp_reg <= gyro_pitch;
                gr_reg <= gyro_roll;
                dt_reg <= (elapsed_us == 20'd0 || elapsed_us > DT_MAX)
                          ? DT_DEF : elapsed_us[16:0];
                fl_reg   <= min_reg;
                fr_reg   <= min_reg;
                br_reg   <= min_reg;
                bl_reg   <= min_reg;
                pang_reg <= pest_rnd[16:0];
                rang_reg <= rest_rnd[16:0];
                stat_reg <= STAT_NO_SENSOR;
            end
            ST_SQ_B: sum_reg <= prod_reg;
            ST_SQ_C:
            begin
                rad_reg  <= sum_reg[31:0] + prod_reg[31:0];
                rem_reg  <= 19'd0;
                root_reg <= 16'd0;
            end
            ST_ROOT:
            begin
                rad_reg  <= {rad_reg[29:0], 2'b00};
                rem_reg  <= root_ge ? (rem_sh - trial) : rem_sh;
                root_reg <= {root_reg[14:0], root_ge};
            end
            ST_CORD_INIT:
            begin
                cx_reg  <= $signed({4'd0, root_reg, 16'd0});
                cy_reg  <= 36'($signed({cord_y, 16'd0}));
                cz_reg  <= 33'sd0;
                acc_reg <= 24'sd0;
            end
            ST_CORD:
            begin
                if (cpos)
                begin
                    cx_reg <= cx_reg + cdx;
                    cy_reg <= cy_reg - cdy;
                    cz_reg <= cz_reg + $signed({3'd0, atan_tbl(cnt_reg[3:0])});
                end
                else
                begin
                    cx_reg <= cx_reg - cdx;
                    cy_reg <= cy_reg + cdy;
                    cz_reg <= cz_reg - $signed({3'd0, atan_tbl(cnt_reg[3:0])});
                end
            end
            ST_CORD_END: acc_reg <= cz_rnd[23:0];
            ST_DIV_INIT:
            begin
                n_reg   <= {rd_mag, 3'b000} + DIV_BIAS;
                neg_reg <= prod_reg[43];
            end
            // hold the low partial product while the high one is formed
            ST_DIV_HI:   sum_reg <= prod_reg;
            ST_DIV_EST:  quo_reg <= q_sum[37:16];
            // one correction step when the remainder still holds the divisor
            ST_DIV_FIX:
            begin
                if (n_rem >= DIV_D)
                    quo_reg <= quo_reg + 22'd1;
            end
            ST_BL_B:  sum_reg <= prod_reg;
            ST_MIX_R: sum_reg <= prod_reg;
            ST_MIX:
            begin
                pang_reg <= pest_rnd[16:0];
                rang_reg <= rest_rnd[16:0];
                if (tilt_hit)
                begin
                    fl_reg   <= min_reg;
                    fr_reg   <= min_reg;
                    br_reg   <= min_reg;
                    bl_reg   <= min_reg;
                    stat_reg <= STAT_TILT;
                end
                else
                begin
                    fl_reg   <= limit(trunc24(mx_b + mx_pa + mx_ra), min_reg, max_reg);
                    fr_reg   <= limit(trunc24(mx_b + mx_pa - mx_ra), min_reg, max_reg);
                    br_reg   <= limit(trunc24(mx_b - mx_pa - mx_ra), min_reg, max_reg);
                    bl_reg   <= limit(trunc24(mx_b - mx_pa + mx_ra), min_reg, max_reg);
                    stat_reg <= STAT_FLY;
                end
            end
            default: ;
        endcase
    end

    assign motor_front_left  = fl_reg;
    assign motor_front_right = fr_reg;
    assign motor_back_right  = br_reg;
    assign motor_back_left   = bl_reg;
    assign pitch_angle       = pang_reg;
    assign roll_angle        = rang_reg;
    assign status            = stat_reg;

    `include "quad_attitude_mixer_core_defines.svh"

    // checks
    `QAMC_ASSERT_IMP(a_ready_excl, in_ready, !out_valid, "ready while result pending")
    `QAMC_ASSERT_NXT(a_busy_after_in, in_valid && in_ready, !in_ready, "ready after accept")
    `QAMC_ASSERT_NXT(a_idle_after_out, out_valid && out_ready, in_ready, "not idle after out")
    `QAMC_ASSERT_IMP(a_cut_min, out_valid && status != STAT_FLY,
        motor_front_left == min_reg && motor_back_right == min_reg, "cutoff not at min")

endmodule

/* tb/sv/quad_attitude_mixer_core_tb.sv */
module quad_attitude_mixer_core_tb;
    import qam_pkg::*;

    localparam logic [3:0] REG_SPARE = 4'd12;
    localparam int PHASE_ITEMS = 215;
    localparam int SETTLE_CYCLES = 160;

    // one sample and one mixer result
    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [16:0] gp;
        logic signed [16:0] gr;
        logic [19:0]        dt;
    } sample_t;

    typedef struct {
        logic [11:0]        motor [4];
        logic signed [16:0] pitch;
        logic signed [16:0] roll;
        logic [1:0]         stat;
    } mix_t;

    // attitude filter and mixer predictor with its queue of pending results
    class attitude_scoreboard;
        longint atan_deg [16];
        logic        sensor_on;
        logic [11:0] base_thr, min_thr, max_thr, gain_p, gain_r;
        logic [7:0]  tilt_deg;
        logic [15:0] alpha;
        longint      est_pitch, est_roll;
        mix_t        pending_mix [$];
        int          errors;

        function new();
            atan_deg = '{754974720, 445687602, 235489088, 119537938, 60000934,
                         30029717, 15018523, 7509720, 3754917, 1877466, 938734,
                         469367, 234684, 117342, 58671, 29335};
            sensor_on = 1'b0;
            base_thr  = 12'd1300;
            min_thr   = 12'd1000;
            max_thr   = 12'd2000;
            gain_p    = 12'd512;
            gain_r    = 12'd512;
            tilt_deg  = 8'd30;
            alpha     = 16'd64225;
            est_pitch = 0;
            est_roll  = 0;
            errors    = 0;
        endfunction

        function void set_reg(logic [3:0] idx, logic [15:0] val);
            case (idx)
                REG_SENSOR: sensor_on = val[0];
                REG_BASE:   base_thr  = val[11:0];
                REG_MIN:    min_thr   = val[11:0];
                REG_MAX:    max_thr   = val[11:0];
                REG_PGAIN:  gain_p    = val[11:0];
                REG_RGAIN:  gain_r    = val[11:0];
                REG_TILT:   tilt_deg  = val[7:0];
                REG_WEIGHT: alpha     = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_mix.size();
        endfunction

        function longint root_floor(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        // vectoring cordic, x >= 0, 16 fraction bits out
        function longint tilt_angle(longint y, longint x);
            longint xs, ys, z, dx, dy;
            xs = x * 65536;
            ys = y * 65536;
            z = 0;
            if (y == 0)
                return 0;
            for (int i = 0; i < 16; i++)
            begin
                dx = ys >>> i;
                dy = xs >>> i;
                if (ys > 0)
                begin
                    xs += dx; ys -= dy; z += atan_deg[i];
                end
                else
                begin
                    xs -= dx; ys += dy; z -= atan_deg[i];
                end
            end
            return (z + 128) >>> 8;
        endfunction

        function longint fuse(longint est, longint rate, longint dt, longint acc);
            longint p, mag, inc, n, w, lim;
            p = rate * dt * 65536;
            mag = (p < 0) ? -p : p;
            inc = (mag + 64000000) / 128000000;
            if (p < 0)
                inc = -inc;
            w = longint'(alpha);
            lim = 64'sd180 <<< 16;
            n = (w * (est + inc) + (65536 - w) * acc + 32768) >>> 16;
            if (n > lim) n = lim;
            if (n < -lim) n = -lim;
            return n;
        endfunction

        function logic [11:0] clamp_thr(longint v);
            if (v < longint'(min_thr)) return min_thr;
            if (v > longint'(max_thr)) return max_thr;
            return v[11:0];
        endfunction

        // accepted input beat: update state and queue the expected result
        function void note_input(sample_t s);
            mix_t e;
            longint ax, ay, az, dt, accp, accr, tl, b, pa, ra, u;
            if (!sensor_on)
            begin
                for (int k = 0; k < 4; k++) e.motor[k] = min_thr;
                e.stat = STAT_NO_SENSOR;
            end
            else
            begin
                ax = s.ax; ay = s.ay; az = s.az;
                dt = s.dt;
                if (dt == 0 || dt > 100000)
                    dt = 4000;
                accp = tilt_angle(ay, root_floor(ax * ax + az * az));
                accr = tilt_angle(-ax, root_floor(ay * ay + az * az));
                est_pitch = fuse(est_pitch, longint'(s.gp), dt, accp);
                est_roll  = fuse(est_roll, longint'(s.gr), dt, accr);
                tl = longint'(tilt_deg) <<< 16;
                if ((est_pitch > tl) || (-est_pitch > tl) || (est_roll > tl) || (-est_roll > tl))
                begin
                    for (int k = 0; k < 4; k++) e.motor[k] = min_thr;
                    e.stat = STAT_TILT;
                end
                else
                begin
                    u = 64'sd1 <<< 24;
                    b = longint'(base_thr) * u;
                    pa = est_pitch * longint'(gain_p);
                    ra = est_roll * longint'(gain_r);
                    e.motor[0] = clamp_thr((b + pa + ra) / u);
                    e.motor[1] = clamp_thr((b + pa - ra) / u);
                    e.motor[2] = clamp_thr((b - pa - ra) / u);
                    e.motor[3] = clamp_thr((b - pa + ra) / u);
                    e.stat = STAT_FLY;
                end
            end
            u = (est_pitch + 128) >>> 8;
            e.pitch = u[16:0];
            u = (est_roll + 128) >>> 8;
            e.roll = u[16:0];
            pending_mix.push_back(e);
        endfunction

        function void cmp(string fname, longint exp_v, longint got_v);
            if (exp_v != got_v)
            begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_result(mix_t got);
            mix_t e;
            if (pending_mix.size() == 0)
            begin
                $display("%0t: unexpected result beat, got status %0d", $time, got.stat);
                errors++;
                return;
            end
            e = pending_mix.pop_front();
            cmp("motor_front_left", e.motor[0], got.motor[0]);
            cmp("motor_front_right", e.motor[1], got.motor[1]);
            cmp("motor_back_right", e.motor[2], got.motor[2]);
            cmp("motor_back_left", e.motor[3], got.motor[3]);
            cmp("pitch_angle", e.pitch, got.pitch);
            cmp("roll_angle", e.roll, got.roll);
            cmp("status", e.stat, got.stat);
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [15:0] accel_x = '0;
    logic signed [15:0] accel_y = '0;
    logic signed [15:0] accel_z = '0;
    logic signed [16:0] gyro_pitch = '0;
    logic signed [16:0] gyro_roll = '0;
    logic [19:0]        elapsed_us = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [11:0]        motor_front_left;
    logic [11:0]        motor_front_right;
    logic [11:0]        motor_back_right;
    logic [11:0]        motor_back_left;
    logic signed [16:0] pitch_angle;
    logic signed [16:0] roll_angle;
    logic [1:0]         status;
    logic               cfg_we = 1'b0;
    logic [3:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    attitude_scoreboard sb = new();
    bit gaps_on = 1'b1;
    bit long_hold_req = 1'b0;

    quad_attitude_mixer_core DUT (.*);

    always #1 clk = ~clk;

    // drive one sample and wait for its input beat
    task automatic send_sample(sample_t s);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        accel_x    <= s.ax;
        accel_y    <= s.ay;
        accel_z    <= s.az;
        gyro_pitch <= s.gp;
        gyro_roll  <= s.gr;
        elapsed_us <= s.dt;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(s);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // caller lowers cfg_we after the last write
    task automatic write_reg(logic [3:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic write_all(logic sen, logic [11:0] base, logic [11:0] mn, logic [11:0] mx,
                             logic [11:0] pg, logic [11:0] rg, logic [7:0] tl,
                             logic [15:0] w);
        in_valid <= 1'b0;
        wait_drained();
        write_reg(REG_SENSOR, {15'd0, sen});
        write_reg(REG_BASE, {4'd0, base});
        write_reg(REG_MIN, {4'd0, mn});
        write_reg(REG_MAX, {4'd0, mx});
        write_reg(REG_PGAIN, {4'd0, pg});
        write_reg(REG_RGAIN, {4'd0, rg});
        write_reg(REG_TILT, {8'd0, tl});
        write_reg(REG_WEIGHT, w);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic sample_t make_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                                            logic signed [15:0] az, logic signed [16:0] gp,
                                            logic signed [16:0] gr, logic [19:0] dt);
        sample_t s;
        s.ax = ax; s.ay = ay; s.az = az; s.gp = gp; s.gr = gr; s.dt = dt;
        return s;
    endfunction

    // mostly near-level flight, some full-range noise
    function automatic sample_t rand_sample();
        sample_t s;
        if ($urandom_range(0, 3) != 0)
        begin
            s.ax = 16'($signed($urandom_range(0, 8000)) - 4000);
            s.ay = 16'($signed($urandom_range(0, 8000)) - 4000);
            s.az = 16'($signed($urandom_range(0, 8000)) + 12000);
            s.gp = 17'($signed($urandom_range(0, 6000)) - 3000);
            s.gr = 17'($signed($urandom_range(0, 6000)) - 3000);
        end
        else
        begin
            s.ax = 16'($urandom);
            s.ay = 16'($urandom);
            s.az = 16'($urandom);
            s.gp = 17'($urandom);
            s.gr = 17'($urandom);
        end
        case ($urandom_range(0, 9))
            0: s.dt = 20'd0;
            1: s.dt = 20'($urandom);
            2: s.dt = 20'd100000 + 20'($urandom_range(0, 1));
            3: s.dt = 20'($urandom_range(1, 100000));
            default: s.dt = 20'($urandom_range(3000, 5000));
        endcase
        return s;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_sample(rand_sample());
    endtask

    // result side: random stalls plus one long hold-off
    int stall_left = 0;
    always @(posedge clk)
    begin
        mix_t got;
        if (out_valid && out_ready)
        begin
            got.motor[0] = motor_front_left;
            got.motor[1] = motor_front_right;
            got.motor[2] = motor_back_right;
            got.motor[3] = motor_back_left;
            got.pitch = pitch_angle;
            got.roll = roll_angle;
            got.stat = status;
            sb.check_result(got);
        end
        if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            stall_left = 600;
        end
        else if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 4);
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sensor absent after reset
        send_sample(make_sample(16'sd100, -16'sd200, 16'sd16384, 17'sd500, -17'sd500, 20'd4000));
        send_sample(rand_sample());

        // directed corners with default tuning
        in_valid <= 1'b0;
        wait_drained();
        write_reg(REG_SENSOR, 16'd1);
        write_reg(REG_SPARE, 16'hFFFF);
        cfg_we <= 1'b0;
        @(posedge clk);
        send_sample(make_sample(16'sd0, 16'sd0, 16'sd0, 17'sd0, 17'sd0, 20'd0));
        send_sample(make_sample(16'sd0, 16'sd0, 16'sd16384, 17'sd0, 17'sd0, 20'd1));
        send_sample(make_sample(-16'sd32768, -16'sd32768, -16'sd32768, 17'sd0, 17'sd0, 20'd100000));
        send_sample(make_sample(16'sd32767, 16'sd32767, 16'sd32767, 17'sd0, 17'sd0, 20'd100001));
        send_sample(make_sample(16'sd0, 16'sd1000, 16'sd0, 17'sd0, 17'sd0, 20'hFFFFF));
        send_sample(make_sample(-16'sd1000, 16'sd0, 16'sd0, 17'sd0, 17'sd0, 20'd4000));
        send_sample(make_sample(16'sd0, 16'sd0, 16'sd16384, 17'sd65535, -17'sd65536, 20'd100000));
        send_sample(make_sample(16'sd0, 16'sd0, 16'sd16384, -17'sd65536, 17'sd65535, 20'd100000));
        send_sample(make_sample(16'sd0, 16'sd0, 16'sd16384, 17'sd0, 17'sd0, 20'd100000));
        send_sample(make_sample(16'sd300, -16'sd300, 16'sd16000, 17'sd200, -17'sd200, 20'd4000));
        long_hold_req = 1'b1;
        random_phase(PHASE_ITEMS);

        // base, gains, max throttle and weight at their top, min throttle at zero, tilt at 180
        write_all(1'b1, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095, 8'd180, 16'hFFFF);
        random_phase(PHASE_ITEMS);

        // all else at zero, min throttle at 4095: crossed throttle limits
        write_all(1'b1, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd0, 8'd0, 16'd0);
        random_phase(PHASE_ITEMS);

        // sensor lost, state must hold
        write_all(1'b0, 12'd1500, 12'd1100, 12'd1900, 12'd700, 12'd300, 8'd45, 16'd60000);
        random_phase(30);

        write_all(1'b1, 12'd1500, 12'd1100, 12'd1900, 12'd700, 12'd300, 8'd90, 16'd60000);
        random_phase(PHASE_ITEMS);

        write_all(1'b1, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom),
                  12'($urandom), 8'($urandom_range(0, 180)), 16'($urandom));
        random_phase(PHASE_ITEMS);

        // closing stretch at full rate
        write_all(1'b1, 12'd1300, 12'd1000, 12'd2000, 12'd512, 12'd512, 8'd30, 16'd64225);
        gaps_on = 1'b0;
        random_phase(PHASE_ITEMS);

        in_valid <= 1'b0;
        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

/* quad_attitude_mixer_core.f */
+incdir+rtl
rtl/qam_pkg.sv
rtl/quad_attitude_mixer_core.sv
tb/sv/quad_attitude_mixer_core_tb.sv
